// ===== rtl/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants and codes for the first-fit boundary-tag allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  // default geometry
  localparam int DefHeapBytes     = 65536;
  localparam int DefChunkBytes    = 256;
  localparam int DefMinBlockBytes = 32;

  // field widths of the transaction payloads
  localparam int ReqSizeW  = 17;
  localparam int BlkAddrW  = 16;
  localparam int GrantW    = 17;
  localparam int StatusW   = 2;

  // action codes
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // status codes
  localparam logic [StatusW-1:0] ST_OK   = 2'd0;
  localparam logic [StatusW-1:0] ST_ZERO = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL = 2'd2;

endpackage

// ===== rtl/ffa_if.sv =====
// ----------------------------------------------------------------------------
// ffa_req_if / ffa_rsp_if
// Valid/ready channels carrying requests into and results out of the allocator.
// ----------------------------------------------------------------------------
interface ffa_req_if import ffa_pkg::*;;
  logic                valid;
  logic                ready;
  logic                action;
  logic [ReqSizeW-1:0] request_size;
  logic [BlkAddrW-1:0] block_addr;

  modport source (output valid, action, request_size, block_addr, input ready);
  modport sink   (input valid, action, request_size, block_addr, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*;;
  logic                valid;
  logic                ready;
  logic [BlkAddrW-1:0] payload_addr;
  logic [GrantW-1:0]   granted_bytes;
  logic [StatusW-1:0]  status;

  modport source (output valid, payload_addr, granted_bytes, status, input ready);
  modport sink   (input valid, payload_addr, granted_bytes, status, output ready);
endinterface

// ===== rtl/ffa_ram.sv =====
// ----------------------------------------------------------------------------
// ffa_ram
// Single-port heap tag memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module ffa_ram #(
  parameter int Depth = 16384,
  parameter int DataW = 17
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [DataW-1:0]         wdata_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

// ===== rtl/first_fit_boundary_tag_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_boundary_tag_allocator_top
// Implicit free list heap allocator with header and footer tags.
// ----------------------------------------------------------------------------
// The heap lives in a single-port tag memory with one word per 4 bytes, and
// every request is worked by one sequencer that issues at most one memory
// access per cycle. After reset the block writes the prologue, the initial
// free chunk (when it fits in the heap) and the epilogue, and takes no
// request until then. An allocate walks the blocks from the start of the heap
// at one tag read per cycle until a fit; a miss grows the heap by a new chunk
// and merges it with a free neighbour. A free walks to the block in the same
// way and then clears the allocated flag in its tags and merges with free
// neighbours. One request is in flight at a time; the finished result sits in
// an output register, so the next request can be taken while it waits to be
// collected.
// ----------------------------------------------------------------------------
module first_fit_boundary_tag_allocator_top import ffa_pkg::*; #(
  parameter int HEAP_BYTES      = DefHeapBytes,
  parameter int CHUNK_BYTES     = DefChunkBytes,
  parameter int MIN_BLOCK_BYTES = DefMinBlockBytes
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ffa_req_if.sink   req_i,
  ffa_rsp_if.source rsp_o
);

  // byte offsets and sizes fit in AW bits, arithmetic has headroom in VW bits
  localparam int AW         = $clog2(HEAP_BYTES + 1);
  localparam int VW         = ((AW > 18) ? AW : 18) + 2;
  localparam int TW         = AW;
  localparam int HeapWords  = HEAP_BYTES / 4;
  localparam int IW         = $clog2(HeapWords);
  // initial chunk rounded up to a multiple of 8
  localparam int InitBytes  = ((CHUNK_BYTES / 4) + ((CHUNK_BYTES / 4) % 2)) * 4;
  localparam bit InitFits   = (16 + InitBytes) <= HEAP_BYTES;
  localparam int InitBreak  = InitFits ? (16 + InitBytes) : 16;

  // sequencer states
  localparam logic [4:0] S_INIT0 = 5'd0;
  localparam logic [4:0] S_INIT1 = 5'd1;
  localparam logic [4:0] S_INIT2 = 5'd2;
  localparam logic [4:0] S_INIT3 = 5'd3;
  localparam logic [4:0] S_INIT4 = 5'd4;
  localparam logic [4:0] S_IDLE  = 5'd5;
  localparam logic [4:0] S_WALK  = 5'd6;
  localparam logic [4:0] S_WALKD = 5'd7;
  localparam logic [4:0] S_GROW  = 5'd8;
  localparam logic [4:0] S_GR_W0 = 5'd9;
  localparam logic [4:0] S_GR_W1 = 5'd10;
  localparam logic [4:0] S_GR_W2 = 5'd11;
  localparam logic [4:0] S_MG_R0 = 5'd12;
  localparam logic [4:0] S_MG_R1 = 5'd13;
  localparam logic [4:0] S_MG_R2 = 5'd14;
  localparam logic [4:0] S_MG_R3 = 5'd15;
  localparam logic [4:0] S_MG_W0 = 5'd16;
  localparam logic [4:0] S_MG_W1 = 5'd17;
  localparam logic [4:0] S_PL_R  = 5'd18;
  localparam logic [4:0] S_PL_D  = 5'd19;
  localparam logic [4:0] S_PL_W0 = 5'd20;
  localparam logic [4:0] S_PL_W1 = 5'd21;
  localparam logic [4:0] S_PL_W2 = 5'd22;
  localparam logic [4:0] S_PL_W3 = 5'd23;
  localparam logic [4:0] S_FR_W0 = 5'd24;
  localparam logic [4:0] S_FR_W1 = 5'd25;
  localparam logic [4:0] S_DONE  = 5'd26;

  logic [4:0]         state_q, state_d;
  logic [VW-1:0]      brk_q, brk_d;
  logic               act_q, act_d;
  logic [VW-1:0]      need_q, need_d;
  logic [VW-1:0]      addr_q, addr_d;
  logic [VW-1:0]      p_q, p_d;
  logic [VW-1:0]      pp_q, pp_d;
  logic [VW-1:0]      sz_q, sz_d;
  logic [VW-1:0]      gsz_q, gsz_d;
  logic [VW-1:0]      msize_q, msize_d;
  logic [VW-1:0]      nsize_q, nsize_d;
  logic               nfree_q, nfree_d;
  logic [VW-1:0]      res_addr_q, res_addr_d;
  logic [VW-1:0]      res_gsz_q, res_gsz_d;
  logic [StatusW-1:0] res_st_q, res_st_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic [BlkAddrW-1:0] out_addr_q, out_addr_d;
  logic [GrantW-1:0]   out_gsz_q, out_gsz_d;
  logic [StatusW-1:0]  out_st_q, out_st_d;
  logic                out_load;

  // memory port
  logic          mem_req, mem_we, mem_en;
  logic [VW-1:0] mem_addr;
  logic [TW-1:0] mem_wdata, mem_rdata;

  // decoded read tag
  logic [VW-1:0] rd_size, np;
  logic          rd_free;

  // request sizing
  logic [VW-1:0] req_ext, need_raw, need_c, addr_c;
  // growth sizing
  logic [VW-1:0] ext_c, grow_bytes;
  // merge decision
  logic          pfree;

  assign rd_size = VW'(mem_rdata) & ~VW'(7);
  assign rd_free = ~mem_rdata[0];
  assign np      = p_q + rd_size;

  assign req_ext  = VW'(req_i.request_size);
  assign need_raw = (req_ext + VW'(15)) & ~VW'(7);
  assign need_c   = (need_raw < VW'(MIN_BLOCK_BYTES)) ? VW'(MIN_BLOCK_BYTES) : need_raw;
  assign addr_c   = VW'(req_i.block_addr);

  assign ext_c      = (need_q > VW'(CHUNK_BYTES)) ? need_q : VW'(CHUNK_BYTES);
  assign grow_bytes = (ext_c & ~VW'(3)) + (ext_c[2] ? VW'(4) : VW'(0));

  // previous block is free, non-empty and does not reach below the heap start
  assign pfree = rd_free && (rd_size != '0) && (rd_size <= pp_q - VW'(8));

  assign mem_en = mem_req && (mem_addr[VW-1:2] < (VW-2)'(HeapWords));

  ffa_ram #(
    .Depth (HeapWords),
    .DataW (TW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr[IW+1:2]),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d    = state_q;
    brk_d      = brk_q;
    act_d      = act_q;
    need_d     = need_q;
    addr_d     = addr_q;
    p_d        = p_q;
    pp_d       = pp_q;
    sz_d       = sz_q;
    gsz_d      = gsz_q;
    msize_d    = msize_q;
    nsize_d    = nsize_q;
    nfree_d    = nfree_q;
    res_addr_d = res_addr_q;
    res_gsz_d  = res_gsz_q;
    res_st_d   = res_st_q;
    mem_req    = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = '0;
    mem_wdata  = '0;

    case (state_q)
      // heap image after reset: prologue tags, initial chunk, epilogue
      S_INIT0: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = VW'(4); mem_wdata = TW'(9);
        state_d = S_INIT1;
      end
      S_INIT1: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = VW'(8); mem_wdata = TW'(9);
        state_d = S_INIT2;
      end
      S_INIT2: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = VW'(12); mem_wdata = InitFits ? TW'(InitBytes) : TW'(1);
        state_d = InitFits ? S_INIT3 : S_IDLE;
      end
      S_INIT3: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = VW'(16 + InitBytes - 8); mem_wdata = TW'(InitBytes);
        state_d = S_INIT4;
      end
      S_INIT4: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = VW'(16 + InitBytes - 4); mem_wdata = TW'(1);
        state_d = S_IDLE;
      end

      S_IDLE: begin
        if (req_i.valid) begin
          act_d      = req_i.action;
          need_d     = need_c;
          addr_d     = addr_c;
          p_d        = VW'(8);
          res_addr_d = '0;
          res_gsz_d  = '0;
          res_st_d   = ST_OK;
          if (req_i.action == ACT_ALLOC && req_i.request_size == '0) begin
            res_st_d = ST_ZERO;
            state_d  = S_DONE;
          end else if (req_i.action == ACT_FREE && addr_c < VW'(16)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_WALK;
          end
        end
      end

      // first header read of the walk
      S_WALK: begin
        if (p_q + VW'(1) < brk_q) begin
          mem_req  = 1'b1;
          mem_addr = p_q - VW'(4);
          state_d  = S_WALKD;
        end else begin
          state_d = (act_q == ACT_ALLOC) ? S_GROW : S_DONE;
        end
      end

      // one header per cycle: evaluate this one, fetch the next
      S_WALKD: begin
        if (act_q == ACT_ALLOC) begin
          if (rd_free && need_q <= rd_size) begin
            pp_d    = p_q;
            state_d = S_PL_R;
          end else if (rd_size == '0) begin
            state_d = S_GROW;
          end else if (np + VW'(1) < brk_q) begin
            p_d      = np;
            mem_req  = 1'b1;
            mem_addr = np - VW'(4);
          end else begin
            state_d = S_GROW;
          end
        end else begin
          if (p_q == addr_q) begin
            if (!rd_free && rd_size != '0) begin
              sz_d    = rd_size;
              pp_d    = p_q;
              state_d = S_FR_W0;
            end else begin
              state_d = S_DONE;
            end
          end else if (rd_size == '0) begin
            state_d = S_DONE;
          end else if (np + VW'(1) < brk_q && np <= addr_q) begin
            p_d      = np;
            mem_req  = 1'b1;
            mem_addr = np - VW'(4);
          end else begin
            state_d = S_DONE;
          end
        end
      end

      // extend the break by a new free chunk
      S_GROW: begin
        if (grow_bytes > VW'(HEAP_BYTES) - brk_q) begin
          res_st_d = ST_FULL;
          state_d  = S_DONE;
        end else begin
          sz_d    = grow_bytes;
          pp_d    = brk_q;
          state_d = S_GR_W0;
        end
      end
      S_GR_W0: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = pp_q - VW'(4); mem_wdata = TW'(sz_q);
        state_d = S_GR_W1;
      end
      S_GR_W1: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = pp_q + sz_q - VW'(8); mem_wdata = TW'(sz_q);
        state_d = S_GR_W2;
      end
      S_GR_W2: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = pp_q + sz_q - VW'(4); mem_wdata = TW'(1);
        brk_d   = brk_q + sz_q;
        state_d = S_MG_R0;
      end

      // coalesce: own header, next header, previous footer
      S_MG_R0: begin
        mem_req  = 1'b1;
        mem_addr = pp_q - VW'(4);
        state_d  = S_MG_R1;
      end
      S_MG_R1: begin
        msize_d  = rd_size;
        mem_req  = 1'b1;
        mem_addr = pp_q + rd_size - VW'(4);
        state_d  = S_MG_R2;
      end
      S_MG_R2: begin
        nfree_d  = rd_free && (msize_q != '0);
        nsize_d  = rd_size;
        mem_req  = 1'b1;
        mem_addr = pp_q - VW'(8);
        state_d  = S_MG_R3;
      end
      S_MG_R3: begin
        if (nfree_q && !pfree) begin
          sz_d    = msize_q + nsize_q;
          state_d = S_MG_W0;
        end else if (!nfree_q && pfree) begin
          pp_d    = pp_q - rd_size;
          sz_d    = msize_q + rd_size;
          state_d = S_MG_W0;
        end else if (nfree_q && pfree) begin
          pp_d    = pp_q - rd_size;
          sz_d    = msize_q + rd_size + nsize_q;
          state_d = S_MG_W0;
        end else begin
          state_d = (act_q == ACT_ALLOC) ? S_PL_R : S_DONE;
        end
      end
      S_MG_W0: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = pp_q - VW'(4); mem_wdata = TW'(sz_q);
        state_d = S_MG_W1;
      end
      S_MG_W1: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = pp_q + sz_q - VW'(8); mem_wdata = TW'(sz_q);
        state_d = (act_q == ACT_ALLOC) ? S_PL_R : S_DONE;
      end

      // place the request, splitting off the tail when big enough
      S_PL_R: begin
        mem_req  = 1'b1;
        mem_addr = pp_q - VW'(4);
        state_d  = S_PL_D;
      end
      S_PL_D: begin
        if (rd_size - need_q >= VW'(MIN_BLOCK_BYTES)) begin
          sz_d    = rd_size - need_q;
          gsz_d   = need_q;
          state_d = S_PL_W0;
        end else begin
          gsz_d   = rd_size;
          state_d = S_PL_W2;
        end
      end
      S_PL_W0: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = pp_q + need_q - VW'(4); mem_wdata = TW'(sz_q);
        state_d = S_PL_W1;
      end
      S_PL_W1: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = pp_q + need_q + sz_q - VW'(8); mem_wdata = TW'(sz_q);
        state_d = S_PL_W2;
      end
      S_PL_W2: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = pp_q - VW'(4); mem_wdata = TW'(gsz_q | VW'(1));
        state_d = S_PL_W3;
      end
      S_PL_W3: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = pp_q + gsz_q - VW'(8); mem_wdata = TW'(gsz_q | VW'(1));
        res_addr_d = pp_q;
        res_gsz_d  = gsz_q;
        state_d    = S_DONE;
      end

      // release: clear the allocated flag, then coalesce
      S_FR_W0: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = pp_q - VW'(4); mem_wdata = TW'(sz_q);
        state_d = S_FR_W1;
      end
      S_FR_W1: begin
        mem_req = 1'b1; mem_we = 1'b1;
        mem_addr = pp_q + sz_q - VW'(8); mem_wdata = TW'(sz_q);
        state_d = S_MG_R0;
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register: a held result is replaced only once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_gsz_d   = out_gsz_q;
    out_st_d    = out_st_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_addr_d  = res_addr_q[BlkAddrW-1:0];
      out_gsz_d   = res_gsz_q[GrantW-1:0];
      out_st_d    = res_st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT0;
      brk_q       <= VW'(InitBreak);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      brk_q       <= brk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    need_q     <= need_d;
    addr_q     <= addr_d;
    p_q        <= p_d;
    pp_q       <= pp_d;
    sz_q       <= sz_d;
    gsz_q      <= gsz_d;
    msize_q    <= msize_d;
    nsize_q    <= nsize_d;
    nfree_q    <= nfree_d;
    res_addr_q <= res_addr_d;
    res_gsz_q  <= res_gsz_d;
    res_st_q   <= res_st_d;
    out_addr_q <= out_addr_d;
    out_gsz_q  <= out_gsz_d;
    out_st_q   <= out_st_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.payload_addr  = out_addr_q;
  assign rsp_o.granted_bytes = out_gsz_q;
  assign rsp_o.status        = out_st_q;

endmodule

// ===== rtl/ffa_checker.sv =====
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks on the allocator result transactions.
// ----------------------------------------------------------------------------
module ffa_checker import ffa_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [BlkAddrW-1:0] payload_addr_i,
  input logic [GrantW-1:0]   granted_bytes_i,
  input logic [StatusW-1:0]  status_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(payload_addr_i)
      && $stable(granted_bytes_i) && $stable(status_i))
    else $error("result changed while stalled");

  // a failed request grants nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != ST_OK |-> payload_addr_i == '0 && granted_bytes_i == '0)
    else $error("failed request carries a grant");

  // grants are 8-byte aligned in address and size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && granted_bytes_i != '0 |->
      granted_bytes_i[2:0] == 3'd0 && payload_addr_i[2:0] == 3'd0)
    else $error("misaligned grant");

  // address and size are given together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (payload_addr_i == '0) == (granted_bytes_i == '0))
    else $error("grant address and size disagree");

endmodule

bind first_fit_boundary_tag_allocator_top ffa_checker u_ffa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .payload_addr_i  (rsp_o.payload_addr),
  .granted_bytes_i (rsp_o.granted_bytes),
  .status_i        (rsp_o.status)
);

// ===== tb/sv/ffa_heap_scoreboard.sv =====
// ----------------------------------------------------------------------------
// ffa_heap_scoreboard
// Shadow heap of the first-fit allocator and the queue of expected results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class ffa_heap_scoreboard;
  typedef struct packed {
    logic [15:0] payload_addr;
    logic [16:0] granted_bytes;
    logic [1:0]  status;
  } alloc_result_t;

  localparam int HeapBytes = ffa_pkg::DefHeapBytes;
  localparam int ChunkBytes = ffa_pkg::DefChunkBytes;
  localparam int MinBlock = ffa_pkg::DefMinBlockBytes;

  bit [31:0]     heap_mem [HeapBytes/4];
  bit [31:0]     brk;
  alloc_result_t pending_results [$];
  int            fail_count;
  int            live_blocks [$];

  function new();
    reset_heap();
  endfunction

  function bit [31:0] rd(bit [31:0] a);
    return ((a >> 2) < HeapBytes/4) ? heap_mem[a >> 2] : 32'd0;
  endfunction

  function void wr(bit [31:0] a, bit [31:0] v);
    if ((a >> 2) < HeapBytes/4) heap_mem[a >> 2] = v;
  endfunction

  function void tag_block(bit [31:0] pp, bit [31:0] sz, bit [31:0] al);
    wr(pp - 4, sz | al);
    wr(pp + sz - 8, sz | al);
  endfunction

  function bit [31:0] coalesce(bit [31:0] pp);
    bit [31:0] sz, nxt, ptag, psz, ntag, nsz;
    bit nf, pf;
    sz = rd(pp - 4) & ~32'h7;
    nxt = pp + sz;
    ptag = rd(pp - 8);
    psz = ptag & ~32'h7;
    ntag = rd(nxt - 4);
    nsz = ntag & ~32'h7;
    nf = !ntag[0] && sz != 0;
    pf = !ptag[0] && psz != 0 && psz <= pp - 8;
    if (nf && !pf) begin
      tag_block(pp, sz + nsz, 0);
      return pp;
    end
    if (pf && !nf) begin
      tag_block(pp - psz, sz + psz, 0);
      return pp - psz;
    end
    if (pf && nf) begin
      tag_block(pp - psz, sz + psz + nsz, 0);
      return pp - psz;
    end
    return pp;
  endfunction

  function bit [31:0] grow_heap(bit [31:0] need);
    bit [31:0] ext, w, pp;
    ext = (need > ChunkBytes) ? need : ChunkBytes;
    w = ext >> 2;
    if (w[0]) w++;
    ext = w * 4;
    if (brk > HeapBytes || ext > HeapBytes - brk) return 0;
    pp = brk;
    tag_block(pp, ext, 0);
    wr(pp + ext - 4, 1);
    brk += ext;
    return coalesce(pp);
  endfunction

  function void reset_heap();
    foreach (heap_mem[i]) heap_mem[i] = 0;
    wr(4, 9);
    wr(8, 9);
    wr(12, 1);
    brk = 16;
    void'(grow_heap(0));
  endfunction

  function bit [31:0] first_fit(bit [31:0] need);
    bit [31:0] p, t, s;
    p = 8;
    while (p + 1 < brk) begin
      t = rd(p - 4);
      s = t & ~32'h7;
      if (!t[0] && need <= s) return p;
      if (s == 0) break;
      p += s;
    end
    return 0;
  endfunction

  function bit is_live(bit [31:0] a);
    bit [31:0] p, t, s;
    p = 8;
    if (a < 16) return 0;
    while (p + 1 < brk && p <= a) begin
      t = rd(p - 4);
      s = t & ~32'h7;
      if (p == a) return t[0] && s != 0;
      if (s == 0) break;
      p += s;
    end
    return 0;
  endfunction

  // note an accepted request and work out its result
  function void note_request(bit act, bit [16:0] size, bit [15:0] addr);
    alloc_result_t r;
    bit [31:0] need, pp, bs;
    r = '0;
    if (act == ffa_pkg::ACT_ALLOC) begin
      if (size == 0) r.status = ffa_pkg::ST_ZERO;
      else begin
        need = (size + 15) & ~32'h7;
        if (need < MinBlock) need = MinBlock;
        pp = first_fit(need);
        if (pp == 0) pp = grow_heap(need);
        if (pp == 0) r.status = ffa_pkg::ST_FULL;
        else begin
          bs = rd(pp - 4) & ~32'h7;
          if (bs - need >= MinBlock) begin
            tag_block(pp + need, bs - need, 0);
            tag_block(pp, need, 1);
            bs = need;
          end else tag_block(pp, bs, 1);
          r.payload_addr = pp[15:0];
          r.granted_bytes = bs[16:0];
          live_blocks.push_back(pp);
        end
      end
    end else if (is_live(addr)) begin
      tag_block(addr, rd(addr - 4) & ~32'h7, 0);
      void'(coalesce(addr));
      foreach (live_blocks[i])
        if (live_blocks[i] == addr) begin
          live_blocks.delete(i);
          break;
        end
    end
    pending_results.push_back(r);
  endfunction

  function void check_result(bit [15:0] pa, bit [16:0] gb, bit [1:0] st);
    alloc_result_t e;
    if (pending_results.size() == 0) begin
      $error("unexpected result: payload_addr %0d", pa);
      fail_count++;
      return;
    end
    e = pending_results.pop_front();
    if (pa !== e.payload_addr) begin
      $error("payload_addr expected %0d actual %0d", e.payload_addr, pa);
      fail_count++;
    end
    if (gb !== e.granted_bytes) begin
      $error("granted_bytes expected %0d actual %0d", e.granted_bytes, gb);
      fail_count++;
    end
    if (st !== e.status) begin
      $error("status expected %0d actual %0d", e.status, st);
      fail_count++;
    end
  endfunction
endclass

// ===== tb/sv/tb_first_fit_boundary_tag_allocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_first_fit_boundary_tag_allocator_top
// Drives allocate and free transactions with random gaps and output stalls,
// and checks every result against a shadow heap kept in a scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_fit_boundary_tag_allocator_top;
  import ffa_pkg::*;

  logic clk_i;
  logic rst_ni;

  ffa_req_if req_if ();
  ffa_rsp_if rsp_if ();

  ffa_heap_scoreboard heap_sb;
  bit   long_hold;   // receiver stays stalled while set
  bit   rx_steady;   // receiver always ready while set
  bit   stim_done;

  first_fit_boundary_tag_allocator_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // generous time limit for the whole run of transactions
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // send one transaction, holding it until the handshake
  task automatic send_req(bit act, bit [16:0] size, bit [15:0] addr);
    req_if.valid        <= 1'b1;
    req_if.action       <= act;
    req_if.request_size <= size;
    req_if.block_addr   <= addr;
    do @(posedge clk_i); while (!req_if.ready);
    heap_sb.note_request(act, size, addr);
    @(negedge clk_i);
  endtask

  task automatic idle_req(int n);
    req_if.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (heap_sb.pending_results.size() != 0) @(negedge clk_i);
  endtask

  // mostly small sizes so the heap does not fill at once
  function automatic bit [16:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 75) return $urandom_range(1, 120);
    if (r < 93) return $urandom_range(121, 2000);
    if (r < 97) return $urandom_range(2001, 20000);
    return $urandom_range(0, 17'h1ffff);
  endfunction

  // frees mostly target live blocks; the rest are bad addresses
  function automatic bit [15:0] pick_free();
    int n;
    n = heap_sb.live_blocks.size();
    if (n != 0 && $urandom_range(0, 9) < 8)
      return heap_sb.live_blocks[$urandom_range(0, n - 1)];
    return $urandom_range(0, 16'hffff);
  endfunction

  // receiver: own stall pattern, with a long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold) rsp_if.ready <= 1'b0;
      else if (rx_steady) rsp_if.ready <= 1'b1;
      else rsp_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // sample results on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      heap_sb.check_result(rsp_if.payload_addr, rsp_if.granted_bytes, rsp_if.status);
  end

  initial begin
    int burst;
    heap_sb = new();
    long_hold = 0;
    rx_steady = 0;
    stim_done = 0;
    req_if.valid = 1'b0;
    req_if.action = ACT_ALLOC;
    req_if.request_size = '0;
    req_if.block_addr = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero size, minimum, split, frees with no neighbour, the upper one or both free
    rx_steady = 1;
    send_req(ACT_ALLOC, 0, 0);
    send_req(ACT_ALLOC, 1, 0);
    send_req(ACT_ALLOC, 24, 0);
    send_req(ACT_ALLOC, 25, 0);
    send_req(ACT_ALLOC, 100, 0);
    send_req(ACT_ALLOC, 40, 0);
    send_req(ACT_FREE, 0, 16);      // free with no free neighbour
    send_req(ACT_FREE, 0, 16);      // double free is ignored
    send_req(ACT_FREE, 0, 80);      // free between two allocated blocks
    send_req(ACT_FREE, 0, 8);       // prologue is ignored
    send_req(ACT_FREE, 0, 20);      // middle of a block
    send_req(ACT_FREE, 0, 16'hffff); // beyond the break
    send_req(ACT_ALLOC, 300, 0);    // grows the heap
    send_req(ACT_ALLOC, 17'h10000, 0); // heap limit
    send_req(ACT_ALLOC, 17'h1ffff, 0);
    send_req(ACT_ALLOC, 5000, 0);
    send_req(ACT_FREE, 0, heap_sb.live_blocks.size() ? heap_sb.live_blocks[0] : 16'd0);
    while (heap_sb.live_blocks.size() != 0)
      send_req(ACT_FREE, 0, heap_sb.live_blocks[heap_sb.live_blocks.size() - 1]);
    drain();
    rx_steady = 0;

    // random bursts with gaps
    for (int i = 0; i < 450; ) begin
      burst = $urandom_range(1, 12);
      for (int j = 0; j < burst; j++, i++) begin
        if (i == 150) begin
          // long receiver hold-off while the sender keeps offering
          fork
            begin
              long_hold = 1;
              repeat (400) @(negedge clk_i);
              long_hold = 0;
            end
          join_none
        end
        if (i == 300) drain();  // pause until every result is back
        if (heap_sb.live_blocks.size() > 40 || $urandom_range(0, 9) < 4)
          send_req(ACT_FREE, pick_size(), pick_free());
        else
          send_req(ACT_ALLOC, pick_size(), $urandom_range(0, 16'hffff));
      end
      if ($urandom_range(0, 3) != 0) idle_req($urandom_range(1, 20));
    end
    drain();
    repeat (100) @(negedge clk_i);

    if (heap_sb.fail_count == 0 && heap_sb.pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
